// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit block allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

  // field widths of the request and response
  localparam int OP_W   = 2;
  localparam int BYTE_W = 13;
  // granule count of a request: ceil(8191 / 8) needs 11 bits
  localparam int NEED_W = 11;
  // log2 of the granule size in bytes
  localparam int GRAN_SHIFT = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_LARGEST = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

endpackage

// ===== hdl/ffa_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_req_if
// Request channel of the allocator: operation and its operands.
// ---------------------------------------------------------------------------
interface ffa_req_if;
  import ffa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] request_bytes;
  logic [BYTE_W-1:0] release_offset;

  modport source (
    output valid, operation, request_bytes, release_offset,
    input  ready
  );

  modport sink (
    input  valid, operation, request_bytes, release_offset,
    output ready
  );
endinterface

// ===== hdl/ffa_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_rsp_if
// Response channel of the allocator: offset, status and largest free size.
// ---------------------------------------------------------------------------
interface ffa_rsp_if;
  import ffa_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_offset;
  logic              success;
  logic [BYTE_W-1:0] largest_free_bytes;

  modport source (
    output valid, payload_offset, success, largest_free_bytes,
    input  ready
  );

  modport sink (
    input  valid, payload_offset, success, largest_free_bytes,
    output ready
  );
endinterface

// ===== hdl/ffa_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/first_fit_block_allocator_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over a pool of 8-byte granules with free-block merging.
// ---------------------------------------------------------------------------
// One request at a time, walked by a small sequencer over a header RAM with
// one entry per granule (start mark, free mark, payload size in granules).
// Timing is set by the single RAM read port: allocate and largest-query
// load and evaluate each block visited, read the neighbor, if any, of each
// free block that does not serve the request and absorb it when it is free,
// then write the split remainder if any and the allocated header, or close
// the walk; free reads the header and marks it free if it is a block start,
// and a zero or unknown request goes straight to the response. The response
// sits in an output register, so the next request is taken while it waits;
// a request only waits at its end while the previous response is not taken.
// After reset a clearing pass writes the initial headers to every granule;
// no request is accepted during it.
// ---------------------------------------------------------------------------
module first_fit_block_allocator_top #(
  parameter int POOL_GRANULES   = 1024,
  parameter int HEADER_GRANULES = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);
  import ffa_pkg::*;

  localparam int AW = $clog2(POOL_GRANULES);
  localparam int NW = AW + 2;
  localparam int CW = ((AW > NEED_W) ? AW : NEED_W) + 2;
  localparam int XW = (AW + 4 > BYTE_W + 1) ? AW + 4 : BYTE_W + 1;

  typedef struct packed {
    logic          start;
    logic          free;
    logic [AW-1:0] size;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_MERGE_EV,
    ST_MERGE_WB,
    ST_SPLIT,
    ST_ALLOC_WB,
    ST_FREE_EV,
    ST_WALK_END,
    ST_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     nx_q, nx_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     best_q, best_d;
  logic [NEED_W-1:0] need_q, need_d;
  op_e               op_q, op_d;
  hdr_t              cur_q, cur_d;
  logic [BYTE_W-1:0] res_off_q, res_off_d;
  logic              res_ok_q, res_ok_d;
  logic [BYTE_W-1:0] res_lg_q, res_lg_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_off_q, out_off_d;
  logic              out_ok_q, out_ok_d;
  logic [BYTE_W-1:0] out_lg_q, out_lg_d;

  // header RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  hdr_t          ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  hdr_t          ram_rdata;

  ffa_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (POOL_GRANULES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // walk arithmetic
  logic [NW-1:0]     nx_x;
  logic              nx_in;
  logic [CW-1:0]     size_x, need_x;
  logic              fits, split;
  logic [XW-1:0]     off_x, lg_x, fg_x, fpos_x;
  logic              free_ok;
  logic [AW-1:0]     fpos;
  logic [BYTE_W:0]   req_round;
  op_e               req_op;

  assign nx_x   = NW'(pos_q) + NW'(HEADER_GRANULES) + NW'(cur_q.size);
  assign nx_in  = nx_x < NW'(POOL_GRANULES);
  assign size_x = CW'(cur_q.size);
  assign need_x = CW'(need_q);
  assign fits   = size_x >= need_x;
  assign split  = size_x > need_x + CW'(HEADER_GRANULES);
  assign off_x  = (XW'(pos_q) + XW'(HEADER_GRANULES)) << GRAN_SHIFT;
  assign lg_x   = XW'(best_q) << GRAN_SHIFT;

  // free: offset must be granule aligned and name a payload inside the pool
  assign fg_x    = XW'(req_i.release_offset[BYTE_W-1:GRAN_SHIFT]);
  assign fpos_x  = fg_x - XW'(HEADER_GRANULES);
  assign free_ok = (req_i.release_offset[GRAN_SHIFT-1:0] == '0)
                && (fg_x >= XW'(HEADER_GRANULES))
                && (fpos_x < XW'(POOL_GRANULES));
  assign fpos    = fpos_x[AW-1:0];

  assign req_round = (BYTE_W+1)'(req_i.request_bytes) + (BYTE_W+1)'(7);
  assign req_op    = op_e'(req_i.operation);

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    nx_d        = nx_q;
    clr_d       = clr_q;
    best_d      = best_q;
    need_d      = need_q;
    op_d        = op_q;
    cur_d       = cur_q;
    res_off_d   = res_off_q;
    res_ok_d    = res_ok_q;
    res_lg_d    = res_lg_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_off_d   = out_off_q;
    out_ok_d    = out_ok_q;
    out_lg_d    = out_lg_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = pos_q;

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == '0) begin
          ram_wdata = '{start: 1'b1, free: 1'b1,
                        size: AW'(POOL_GRANULES - HEADER_GRANULES)};
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(POOL_GRANULES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          op_d      = req_op;
          res_off_d = '0;
          res_ok_d  = 1'b0;
          res_lg_d  = '0;
          pos_d     = '0;
          best_d    = '0;
          need_d    = req_round[BYTE_W:GRAN_SHIFT];
          case (req_op)
            OP_ALLOC: begin
              if (req_i.request_bytes == '0) begin
                state_d = ST_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = ST_LOAD;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                ram_re    = 1'b1;
                ram_raddr = fpos;
                pos_d     = fpos;
                state_d   = ST_FREE_EV;
              end else begin
                state_d = ST_RESP;
              end
            end
            OP_LARGEST: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = ST_LOAD;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_LOAD: begin
        cur_d   = ram_rdata;
        state_d = ST_EVAL;
      end

      ST_EVAL: begin
        if (cur_q.free) begin
          if (op_q == OP_ALLOC && fits) begin
            res_off_d = off_x[BYTE_W-1:0];
            res_ok_d  = 1'b1;
            state_d   = split ? ST_SPLIT : ST_ALLOC_WB;
          end else if (nx_in) begin
            // look at the neighbor for a possible merge
            ram_re    = 1'b1;
            ram_raddr = nx_x[AW-1:0];
            nx_d      = nx_x[AW-1:0];
            state_d   = ST_MERGE_EV;
          end else begin
            if (op_q == OP_LARGEST && cur_q.size > best_q) begin
              best_d = cur_q.size;
            end
            state_d = ST_WALK_END;
          end
        end else if (nx_in) begin
          ram_re    = 1'b1;
          ram_raddr = nx_x[AW-1:0];
          pos_d     = nx_x[AW-1:0];
          state_d   = ST_LOAD;
        end else begin
          state_d = ST_WALK_END;
        end
      end

      ST_MERGE_EV: begin
        if (ram_rdata.start && ram_rdata.free) begin
          // absorb neighbor, header included
          ram_we     = 1'b1;
          ram_waddr  = nx_q;
          ram_wdata  = '0;
          cur_d.size = cur_q.size + AW'(HEADER_GRANULES) + ram_rdata.size;
          state_d    = ST_MERGE_WB;
        end else begin
          if (op_q == OP_LARGEST && cur_q.size > best_q) begin
            best_d = cur_q.size;
          end
          ram_re    = 1'b1;
          ram_raddr = nx_q;
          pos_d     = nx_q;
          state_d   = ST_LOAD;
        end
      end

      ST_MERGE_WB: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = '{start: 1'b1, free: 1'b1, size: cur_q.size};
        state_d   = ST_EVAL;
      end

      ST_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q + AW'(HEADER_GRANULES) + AW'(need_q);
        ram_wdata = '{start: 1'b1, free: 1'b1,
                      size: cur_q.size - AW'(need_q) - AW'(HEADER_GRANULES)};
        cur_d.size = AW'(need_q);
        state_d    = ST_ALLOC_WB;
      end

      ST_ALLOC_WB: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = '{start: 1'b1, free: 1'b0, size: cur_q.size};
        state_d   = ST_RESP;
      end

      ST_FREE_EV: begin
        if (ram_rdata.start) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = '{start: 1'b1, free: 1'b1, size: ram_rdata.size};
          res_ok_d  = 1'b1;
        end
        state_d = ST_RESP;
      end

      ST_WALK_END: begin
        if (op_q == OP_LARGEST) begin
          res_ok_d = 1'b1;
          res_lg_d = lg_x[BYTE_W-1:0];
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_off_d   = res_off_q;
          out_ok_d    = res_ok_q;
          out_lg_d    = res_lg_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    nx_q      <= nx_d;
    best_q    <= best_d;
    need_q    <= need_d;
    op_q      <= op_d;
    cur_q     <= cur_d;
    res_off_q <= res_off_d;
    res_ok_q  <= res_ok_d;
    res_lg_q  <= res_lg_d;
    out_off_q <= out_off_d;
    out_ok_q  <= out_ok_d;
    out_lg_q  <= out_lg_d;
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.payload_offset     = out_off_q;
  assign rsp_o.success            = out_ok_q;
  assign rsp_o.largest_free_bytes = out_lg_q;

  // no request is taken while the header RAM is being cleared
  a_no_req_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !req_i.ready)
    else $error("request accepted during clearing pass");

  // every visited position holds a block header
  a_walk_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> cur_q.start)
    else $error("walk landed off a block start");

  // header writes stay inside the pool
  a_waddr_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (NW'(ram_waddr) < NW'(POOL_GRANULES)))
    else $error("header write outside the pool");

  // a failed request reports no offset and no size
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.success) |->
      (rsp_o.payload_offset == '0 && rsp_o.largest_free_bytes == '0))
    else $error("failed response carries data");

  // a merge write-back always follows a merge
  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE_WB) |-> ($past(state_q) == ST_MERGE_EV))
    else $error("merge write-back out of sequence");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit block allocator.
// ---------------------------------------------------------------------------
// Requests go in on the request channel, and a shadow copy of the granule
// pool computes each response at the moment its request is accepted. The
// responses are then checked in order against that copy. Directed edge and
// merge cases run first, then a hold-off that backs the allocator up, then
// random allocate/free/query traffic, with idle bursts on both sides in most
// chunks, and last a tail with no idling.
// ---------------------------------------------------------------------------
module testbench;
  import ffa_pkg::*;

  localparam int POOL         = 1024;
  localparam int HDR          = 2;
  localparam int GRAN_BYTES   = 8;
  localparam int STALL_LIMIT  = 12000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_offset;
    logic              success;
    logic [BYTE_W-1:0] largest_free_bytes;
  } alloc_rsp_t;

  logic clk;
  logic rst_n;

  ffa_req_if req_if ();
  ffa_rsp_if rsp_if ();

  first_fit_block_allocator_top #(
    .POOL_GRANULES  (POOL),
    .HEADER_GRANULES(HDR)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the header store
  bit          blk_start[POOL];
  bit          blk_free[POOL];
  int unsigned blk_size[POOL];

  alloc_rsp_t  pending_rsp[$];
  int unsigned live_offsets[$];

  int unsigned mismatches;
  int unsigned n_alloc, n_alloc_fail, n_free, n_free_bad, n_query, n_none;
  int unsigned merges_seen;
  bit          idling;
  bit          hold_req;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- pool model

  function automatic void pool_reset();
    for (int i = 0; i < POOL; i++) begin
      blk_start[i] = 1'b0;
      blk_free[i]  = 1'b0;
      blk_size[i]  = 0;
    end
    blk_start[0] = 1'b1;
    blk_free[0]  = 1'b1;
    blk_size[0]  = POOL - HDR;
  endfunction

  function automatic int unsigned block_after(int unsigned pos);
    return pos + HDR + blk_size[pos];
  endfunction

  // swallow the following block, header included, when it is free
  function automatic bit absorb_next(int unsigned pos);
    int unsigned nx;
    nx = block_after(pos);
    if (nx >= POOL || !blk_start[nx] || !blk_free[nx]) return 1'b0;
    blk_size[pos] += HDR + blk_size[nx];
    blk_start[nx] = 1'b0;
    blk_free[nx]  = 1'b0;
    blk_size[nx]  = 0;
    merges_seen++;
    return 1'b1;
  endfunction

  function automatic bit carve_block(int unsigned bytes, output int unsigned offset);
    int unsigned want;
    int unsigned pos;
    int unsigned rest;
    offset = 0;
    if (bytes == 0) return 1'b0;
    want = (bytes + GRAN_BYTES - 1) / GRAN_BYTES;
    pos  = 0;
    while (pos < POOL) begin
      if (blk_free[pos]) begin
        if (blk_size[pos] >= want) begin
          if (blk_size[pos] > want + HDR) begin
            rest = pos + HDR + want;
            blk_start[rest] = 1'b1;
            blk_free[rest]  = 1'b1;
            blk_size[rest]  = blk_size[pos] - want - HDR;
            blk_size[pos]   = want;
          end
          blk_free[pos] = 1'b0;
          offset = (pos + HDR) * GRAN_BYTES;
          return 1'b1;
        end
        if (absorb_next(pos)) continue;
      end
      pos = block_after(pos);
    end
    return 1'b0;
  endfunction

  function automatic bit mark_free(int unsigned off);
    int unsigned g;
    if (off % GRAN_BYTES != 0) return 1'b0;
    g = off / GRAN_BYTES;
    if (g < HDR) return 1'b0;
    if (g - HDR >= POOL || !blk_start[g - HDR]) return 1'b0;
    blk_free[g - HDR] = 1'b1;
    return 1'b1;
  endfunction

  function automatic int unsigned widest_free();
    int unsigned best;
    int unsigned pos;
    best = 0;
    pos  = 0;
    while (pos < POOL) begin
      if (blk_free[pos]) begin
        if (absorb_next(pos)) continue;
        if (blk_size[pos] > best) best = blk_size[pos];
      end
      pos = block_after(pos);
    end
    return best * GRAN_BYTES;
  endfunction

  function automatic alloc_rsp_t predict_response(op_e op, logic [BYTE_W-1:0] rb,
                                                  logic [BYTE_W-1:0] ro);
    alloc_rsp_t  r;
    int unsigned off;
    r = '0;
    case (op)
      OP_ALLOC: begin
        r.success = carve_block(32'(rb), off);
        r.payload_offset = off[BYTE_W-1:0];
        n_alloc++;
        if (!r.success) n_alloc_fail++;
      end
      OP_FREE: begin
        r.success = mark_free(32'(ro));
        n_free++;
        if (!r.success) n_free_bad++;
      end
      OP_LARGEST: begin
        off = widest_free();
        r.largest_free_bytes = off[BYTE_W-1:0];
        r.success = 1'b1;
        n_query++;
      end
      default: n_none++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input op_e op, input logic [BYTE_W-1:0] rb,
                              input logic [BYTE_W-1:0] ro, output alloc_rsp_t want);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.operation      <= op;
    req_if.request_bytes  <= rb;
    req_if.release_offset <= ro;
    do @(posedge clk); while (!req_if.ready);
    want = predict_response(op, rb, ro);
    pending_rsp.push_back(want);
    @(negedge clk);
  endtask

  task automatic send_plain(op_e op, int unsigned rb, int unsigned ro);
    alloc_rsp_t want;
    send_request(op, rb[BYTE_W-1:0], ro[BYTE_W-1:0], want);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned idx;
    logic [BYTE_W-1:0] rb;
    logic [BYTE_W-1:0] ro;
    alloc_rsp_t want;
    pick = $urandom_range(0, 99);
    rb   = BYTE_W'($urandom);
    ro   = BYTE_W'($urandom);
    // keep the pool from filling up for good
    if (live_offsets.size() > 48 && pick < 45) pick += 35;
    if (pick < 45) begin
      idx = $urandom_range(0, 9);
      if (idx < 6)      rb = BYTE_W'($urandom_range(1, 64));
      else if (idx < 9) rb = BYTE_W'($urandom_range(1, 1024));
      else              rb = BYTE_W'($urandom_range(1, 8191));
      send_request(OP_ALLOC, rb, ro, want);
      if (want.success) live_offsets.push_back(32'(want.payload_offset));
    end else if (pick < 80) begin
      if (live_offsets.size() != 0) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        ro  = BYTE_W'(live_offsets[idx]);
        // sometimes keep it listed so that it gets freed twice
        if ($urandom_range(0, 9) != 0) live_offsets.delete(idx);
      end
      send_request(OP_FREE, rb, ro, want);
    end else if (pick < 88) begin
      send_request(OP_LARGEST, rb, ro, want);
    end else if (pick < 94) begin
      if ($urandom_range(0, 1) == 0) ro[2:0] = 3'd0;
      send_request(OP_FREE, rb, ro, want);
    end else if (pick < 97) begin
      send_request(OP_NONE, rb, ro, want);
    end else begin
      send_request(OP_ALLOC, '0, ro, want);
    end
  endtask

  // response side: random stalls, plus the long hold-off when asked
  initial begin : rsp_drain
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat (idling ? $urandom_range(1, 16) : 1) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  initial begin : rsp_check
    alloc_rsp_t want;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("response with no request outstanding", 1, 0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_if.payload_offset !== want.payload_offset)
            report_mismatch("payload_offset", 32'(rsp_if.payload_offset),
                            32'(want.payload_offset));
          if (rsp_if.success !== want.success)
            report_mismatch("success", 32'(rsp_if.success), 32'(want.success));
          if (rsp_if.largest_free_bytes !== want.largest_free_bytes)
            report_mismatch("largest_free_bytes", 32'(rsp_if.largest_free_bytes),
                            32'(want.largest_free_bytes));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  task automatic test_edge_cases();
    send_plain(OP_LARGEST, 0, 0);
    send_plain(OP_ALLOC, 0, 8191);
    send_plain(OP_NONE, 8191, 8191);
    send_plain(OP_ALLOC, 8191, 0);
    // whole pool in one block, no split
    send_plain(OP_ALLOC, (POOL - HDR) * GRAN_BYTES, 0);
    send_plain(OP_LARGEST, 0, 0);
    send_plain(OP_ALLOC, 1, 0);
    send_plain(OP_FREE, 0, HDR * GRAN_BYTES);
    send_plain(OP_FREE, 0, HDR * GRAN_BYTES);
    send_plain(OP_FREE, 0, HDR * GRAN_BYTES + 1);
    send_plain(OP_FREE, 8191, 0);
    send_plain(OP_FREE, 0, GRAN_BYTES);
    send_plain(OP_FREE, 0, 8191);
    send_plain(OP_FREE, 0, 8184);
  endtask

  task automatic test_merge_walk();
    send_plain(OP_ALLOC, 1, 0);
    send_plain(OP_ALLOC, 8, 0);
    send_plain(OP_ALLOC, 9, 0);
    send_plain(OP_FREE, 0, 16);
    send_plain(OP_FREE, 0, 40);
    // too small at the first block, so it absorbs the freed neighbor
    send_plain(OP_ALLOC, 24, 0);
    send_plain(OP_FREE, 0, 64);
    send_plain(OP_LARGEST, 0, 0);
    send_plain(OP_ALLOC, 8191, 0);
    send_plain(OP_FREE, 0, 16);
    send_plain(OP_LARGEST, 0, 0);
  endtask

  task automatic test_backpressure();
    idling   = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_random_request();
    idling = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 7; chunk++) begin
      idling = (chunk % 3 != 2);
      repeat (100) send_random_request();
    end
  endtask

  task automatic test_quiet_tail();
    idling = 1'b0;
    repeat (100) send_random_request();
  endtask

  initial begin : main
    req_if.valid          = 1'b0;
    req_if.operation      = OP_NONE;
    req_if.request_bytes  = '0;
    req_if.release_offset = '0;
    mismatches   = 0;
    n_alloc      = 0;
    n_alloc_fail = 0;
    n_free       = 0;
    n_free_bad   = 0;
    n_query      = 0;
    n_none       = 0;
    merges_seen  = 0;
    idling       = 1'b1;
    hold_req     = 1'b0;
    pool_reset();
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_edge_cases();
    test_merge_walk();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();

    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d allocates (%0d refused), %0d frees (%0d rejected),",
             n_alloc, n_alloc_fail, n_free, n_free_bad);
    $display("%0d largest-block queries, %0d no-ops and %0d block merges",
             n_query, n_none, merges_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== first_fit_block_allocator_top.f =====
hdl/ffa_pkg.sv
hdl/ffa_req_if.sv
hdl/ffa_rsp_if.sv
hdl/ffa_ram.sv
hdl/first_fit_block_allocator_top.sv
tb/testbench.sv
